// File: hdl/dense_handle_allocator_macros.svh
// Assertion helpers for the handle allocator
`ifndef DENSE_HANDLE_ALLOCATOR_MACROS_SVH
`define DENSE_HANDLE_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
`define DHA_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DHA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define DHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DHA_ASSERT_NOW(lbl, prop, msg)
`define DHA_ASSERT_IMPL(lbl, ante, cons, msg)
`define DHA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hdl/dha_pkg.sv
package dha_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int POOL_W       = 11;
  localparam int HANDLE_W     = 10;
  localparam int STATUS_W     = 2;
  localparam int LIVE_W       = 11;
  localparam logic [POOL_W-1:0] POOL_RESET = 11'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_RANGE    = 2'd2,
    STS_NOT_LIVE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_COMMIT
  } dha_state_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic wr_swap;
    logic wr_final;
    logic res_load;
  } dha_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_free;
    logic early_err;
    logic not_live;
  } dha_sts_t;

endpackage

// File: hdl/dense_handle_allocator.sv
// Dense handle allocator: hands out and takes back handles, live ones packed.
// Input channel (in_valid/in_ready): in_operation 0 allocates, 1 frees
// in_handle. Result channel (out_valid/out_ready): one transfer per request
// carrying the handle given, a status code and the live count afterwards.
// cfg_we/cfg_wdata write pool_size; write it only while the block is idle.
// Flow: an accepted request goes to S_EVAL, where an allocate or rejected
// request loads its result; a successful free loads it from S_COMMIT. One
// request is handled at a time, so the next is taken only after the last
// result is loaded. The single write port of each table sets the free path:
// the two moved entries go in from S_EVAL, then S_COMMIT, after registered reads.
// Reset: both tables are swept back to identity, one entry a cycle, so
// in_ready stays low until the sweep has written the last entry; the live
// count clears at once and pool_size returns to 1024.
// A stalled receiver holds the result in the output register; the next
// request may be accepted meanwhile but its result waits until that
// transfer completes.
`include "dense_handle_allocator_macros.svh"

module dense_handle_allocator
  import dha_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [POOL_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic [HANDLE_W-1:0] in_handle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [HANDLE_W-1:0] out_given_handle,
  output logic [STATUS_W-1:0] out_status,
  output logic [LIVE_W-1:0]   out_live_total
);

  dha_cmd_t   cmd;
  dha_sts_t   sts;
  logic [3:0] tbl_cmd;

  assign tbl_cmd = {cmd.clr_step, cmd.capture, cmd.wr_swap, cmd.wr_final};

  dha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dha_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_operation     (in_operation),
    .in_handle        (in_handle),
    .out_given_handle (out_given_handle),
    .out_status       (out_status),
    .out_live_total   (out_live_total),
    .cmd              (cmd),
    .sts              (sts)
  );

  `DHA_ASSERT_NOW(a_cmd_onehot, $onehot0(tbl_cmd), "table commands overlap")
  `DHA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accept while busy")
  `DHA_ASSERT_IMPL(a_no_write_when_idle, in_ready, !(cmd.wr_swap || cmd.wr_final), "idle write")
  `DHA_ASSERT_IMPL(a_err_zero_handle, out_valid && (out_status != STS_OK), out_given_handle == '0, "bad handle")

endmodule

// File: hdl/dha_ctrl.sv
module dha_ctrl
  import dha_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dha_sts_t sts,
  output dha_cmd_t cmd
);

  dha_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.early_err || !sts.op_free || sts.not_live) begin
          if (out_free) begin
            cmd.res_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.wr_swap = 1'b1;
          state_nxt   = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.wr_final = 1'b1;
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

// File: hdl/dha_dp.sv
module dha_dp
  import dha_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [POOL_W-1:0]   cfg_wdata,
  input  logic                in_operation,
  input  logic [HANDLE_W-1:0] in_handle,
  output logic [HANDLE_W-1:0] out_given_handle,
  output logic [STATUS_W-1:0] out_status,
  output logic [LIVE_W-1:0]   out_live_total,
  input  dha_cmd_t            cmd,
  output dha_sts_t            sts
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POOL_W) ? CNT_W : POOL_W;
  localparam logic [CMP_W-1:0] CAP_CMP  = CMP_W'(CAPACITY);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

  logic [IDX_W-1:0] d2h_mem [CAPACITY];
  logic [IDX_W-1:0] h2d_mem [CAPACITY];

  logic [POOL_W-1:0]   pool_size_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    clr_idx_r;
  logic                op_r;
  logic [IDX_W-1:0]    h_r;
  status_t             err_r, err_nxt;
  logic [IDX_W-1:0]    d2h_q, h2d_q;
  logic [HANDLE_W-1:0] given_r;
  status_t             status_r, status_nxt;
  logic [LIVE_W-1:0]   live_r;

  logic [CMP_W-1:0] pool_ext, limit;
  logic [IDX_W-1:0] last_idx, d2h_ra, h2d_ra;
  logic             d2h_we, h2d_we;
  logic [IDX_W-1:0] d2h_wa, d2h_wd, h2d_wa, h2d_wd;
  logic             alloc_ok;

  assign pool_ext = CMP_W'(pool_size_r);
  assign limit    = (pool_ext > CAP_CMP) ? CAP_CMP : pool_ext;
  assign last_idx = IDX_W'(count_r - 1'b1);
  assign d2h_ra   = (in_operation == OP_FREE) ? last_idx : IDX_W'(count_r);
  assign h2d_ra   = IDX_W'(in_handle);

  always_comb begin
    if (in_operation == OP_ALLOC) begin
      err_nxt = (CMP_W'(count_r) >= limit) ? STS_FULL : STS_OK;
    end else begin
      err_nxt = (CMP_W'(in_handle) >= limit) ? STS_RANGE : STS_OK;
    end
  end

  assign sts.clr_last  = (clr_idx_r == IDX_LAST);
  assign sts.op_free   = (op_r == OP_FREE);
  assign sts.early_err = (err_r != STS_OK);
  assign sts.not_live  = (CMP_W'(h2d_q) >= CMP_W'(count_r));

  // table write ports
  always_comb begin
    d2h_we = 1'b0;
    d2h_wa = '0;
    d2h_wd = '0;
    h2d_we = 1'b0;
    h2d_wa = '0;
    h2d_wd = '0;
    priority if (cmd.clr_step) begin
      d2h_we = 1'b1;
      d2h_wa = clr_idx_r;
      d2h_wd = clr_idx_r;
      h2d_we = 1'b1;
      h2d_wa = clr_idx_r;
      h2d_wd = clr_idx_r;
    end else if (cmd.wr_swap) begin
      d2h_we = 1'b1;
      d2h_wa = h2d_q;
      d2h_wd = d2h_q;
      h2d_we = 1'b1;
      h2d_wa = d2h_q;
      h2d_wd = h2d_q;
    end else if (cmd.wr_final) begin
      d2h_we = 1'b1;
      d2h_wa = last_idx;
      d2h_wd = h_r;
      h2d_we = 1'b1;
      h2d_wa = h_r;
      h2d_wd = last_idx;
    end else begin
      d2h_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (d2h_we) begin
      d2h_mem[d2h_wa] <= d2h_wd;
    end
    if (cmd.capture) begin
      d2h_q <= d2h_mem[d2h_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (h2d_we) begin
      h2d_mem[h2d_wa] <= h2d_wd;
    end
    if (cmd.capture) begin
      h2d_q <= h2d_mem[h2d_ra];
    end
  end

  assign alloc_ok = (op_r == OP_ALLOC) && (err_r == STS_OK);

  always_comb begin
    priority if (cmd.res_load && alloc_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.wr_final) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_comb begin
    priority if (err_r != STS_OK) begin
      status_nxt = err_r;
    end else if (sts.op_free && sts.not_live) begin
      status_nxt = STS_NOT_LIVE;
    end else begin
      status_nxt = STS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= POOL_RESET;
      count_r     <= '0;
      clr_idx_r   <= '0;
    end else begin
      if (cfg_we) begin
        pool_size_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_operation;
      h_r   <= IDX_W'(in_handle);
      err_r <= err_nxt;
    end
    if (cmd.res_load) begin
      given_r  <= alloc_ok ? HANDLE_W'(d2h_q) : '0;
      status_r <= status_nxt;
      live_r   <= LIVE_W'(count_nxt);
    end
  end

  assign out_given_handle = given_r;
  assign out_status       = status_r;
  assign out_live_total   = live_r;

endmodule
